// File: rtl/xcd_pkg.sv
// Shared constants and types for the XOR-checked command deframer.
// No dependencies; xcd_in_reg, xcd_parser, xcd_out_reg and the top level import this package.
package xcd_pkg;

  localparam int unsigned MAX_FRAME = 64;   // bytes; frame closes on its own here
  localparam int unsigned MIN_FRAME = 7;    // shortest frame that yields a result
  localparam int unsigned COUNT_W   = 7;    // holds byte positions 0 .. MAX_FRAME-1

  localparam logic [7:0] START_MARK = 8'hAA;

  // Byte positions inside a frame
  localparam logic [COUNT_W-1:0] POS_START  = COUNT_W'(0);
  localparam logic [COUNT_W-1:0] POS_CMD    = COUNT_W'(1);
  localparam logic [COUNT_W-1:0] POS_LEN    = COUNT_W'(2);
  localparam logic [COUNT_W-1:0] POS_PAY_LO = COUNT_W'(3);
  localparam logic [COUNT_W-1:0] POS_PAY_HI = COUNT_W'(6);
  localparam logic [COUNT_W-1:0] POS_MIN_LAST = COUNT_W'(MIN_FRAME - 1);
  localparam logic [COUNT_W-1:0] POS_MAX_LAST = COUNT_W'(MAX_FRAME - 1);

  // frame_status codes
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_CSUM_ERR = 1'b1;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_frame;
  } rx_item_t;

  typedef struct packed {
    logic        frame_status;
    logic [7:0]  command_code;
    logic [7:0]  length_byte;
    logic [31:0] payload_word;
    logic [7:0]  check_byte;
  } frame_result_t;

endpackage

// File: rtl/xcd_in_if.sv
// Byte request channel of the deframer: valid/ready plus one received byte.
// Depends on nothing.
interface xcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       end_of_frame;

  modport source (output valid, output rx_byte, output end_of_frame, input ready);
  modport sink   (input valid, input rx_byte, input end_of_frame, output ready);
endinterface

// File: rtl/xcd_out_if.sv
// Result channel of the deframer: valid/ready plus one decoded frame.
// Depends on nothing.
interface xcd_out_if;
  logic        valid;
  logic        ready;
  logic        frame_status;
  logic [7:0]  command_code;
  logic [7:0]  length_byte;
  logic [31:0] payload_word;
  logic [7:0]  check_byte;

  modport source (output valid, output frame_status, output command_code,
                  output length_byte, output payload_word, output check_byte,
                  input ready);
  modport sink   (input valid, input frame_status, input command_code,
                  input length_byte, input payload_word, input check_byte,
                  output ready);
endinterface

// File: rtl/xcd_in_reg.sv
// Input register of the deframer: holds one received byte until the parser
// consumes it. Depends on xcd_pkg.
module xcd_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  xcd_pkg::rx_item_t item_i,
  output logic              ready_o,
  output logic              item_valid_o,
  output xcd_pkg::rx_item_t item_o,
  input  logic              pop_i
);
  import xcd_pkg::*;

  logic     valid_q, valid_d;
  rx_item_t item_q;

  assign ready_o = !valid_q || pop_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// File: rtl/xcd_parser.sv
// Frame parser: per-byte position count, start check, running XOR and held
// header fields; forms the result when a frame closes. Depends on xcd_pkg.
module xcd_parser (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   item_valid_i,
  input  xcd_pkg::rx_item_t      item_i,
  output logic                   pop_o,
  input  logic                   out_free_i,
  output logic                   push_o,
  output xcd_pkg::frame_result_t result_o
);
  import xcd_pkg::*;

  logic [COUNT_W-1:0] count_q, count_d;
  logic               start_q, start_d;
  logic [7:0]         xor_q, xor_d;
  logic [7:0]         cmd_q, len_q;
  logic [31:0]        pay_q;

  logic [7:0]         b;
  logic [7:0]         cmd_cur, len_cur;
  logic [31:0]        pay_cur;
  logic [COUNT_W-1:0] lane_w;
  logic [1:0]         lane;
  logic               closing;
  logic               res_valid;

  assign b      = item_i.rx_byte;
  assign lane_w = count_q - POS_PAY_LO;
  assign lane   = lane_w[1:0];

  // Header fields as they stand after the current byte
  always_comb begin
    cmd_cur = cmd_q;
    len_cur = len_q;
    pay_cur = pay_q;
    if (count_q == POS_CMD) begin
      cmd_cur = b;
    end
    if (count_q == POS_LEN) begin
      len_cur = b;
    end
    if (count_q >= POS_PAY_LO && count_q <= POS_PAY_HI) begin
      pay_cur[{lane, 3'b000} +: 8] = b;
    end
  end

  assign closing   = item_i.end_of_frame || (count_q >= POS_MAX_LAST);
  assign res_valid = closing && (count_q >= POS_MIN_LAST) && start_q;

  // Hold the byte back only when it makes a result and the output is full
  assign pop_o  = item_valid_i && (!res_valid || out_free_i);
  assign push_o = pop_o && res_valid;

  assign result_o.frame_status = (xor_q != b) ? STATUS_CSUM_ERR : STATUS_OK;
  assign result_o.command_code = cmd_cur;
  assign result_o.length_byte  = len_cur;
  assign result_o.payload_word = pay_cur;
  assign result_o.check_byte   = b;

  always_comb begin
    count_d = count_q;
    start_d = start_q;
    xor_d   = xor_q;
    if (pop_o) begin
      if (closing) begin
        count_d = '0;
        start_d = 1'b0;
        xor_d   = '0;
      end else begin
        count_d = count_q + COUNT_W'(1);
        if (count_q == POS_START) begin
          start_d = (b == START_MARK);
        end else begin
          xor_d = xor_q ^ b;   // byte 0 is left out of the checksum
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      start_q <= 1'b0;
      xor_q   <= '0;
    end else begin
      count_q <= count_d;
      start_q <= start_d;
      xor_q   <= xor_d;
    end
  end

  // Every header lane is rewritten before a frame can produce a result
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= cmd_cur;
      len_q <= len_cur;
      pay_q <= pay_cur;
    end
  end

endmodule

// File: rtl/xcd_out_reg.sv
// Result register: holds one decoded frame until the receiver takes it.
// Depends on xcd_pkg.
module xcd_out_reg (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  xcd_pkg::frame_result_t result_i,
  output logic                   free_o,
  output logic                   valid_o,
  output xcd_pkg::frame_result_t result_o,
  input  logic                   ready_i
);
  import xcd_pkg::*;

  logic          valid_q, valid_d;
  frame_result_t result_q;

  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (free_o) begin
      valid_d = push_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && free_o) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

// File: rtl/xor_checked_command_deframer.sv
// XOR-checked command deframer, top level.
// Depends on xcd_pkg, xcd_in_if, xcd_out_if, xcd_in_reg, xcd_parser, xcd_out_reg.
//
// Usage:
//   in_i  : one received byte per request; end_of_frame marks the last byte
//           of a frame. A frame also closes by itself at its MAX_FRAME-th byte.
//   res_o : one request per frame that is at least 7 bytes long and starts
//           with 0xAA: command, length, payload bytes 3..6, check byte, and
//           frame_status (ok, or checksum error when the last byte differs
//           from the XOR of bytes 1 .. n-2). Other frames are dropped.
// Path: the closing byte is registered in the input register; the parser forms
//   the result from it combinationally, and the result register loads it when
//   it is free or being taken.
// Throughput: one byte per cycle while no result is held back by res_o; the
//   per-byte update in the parser (count, XOR, header capture) sets it.
// Reset: clears the frame position, start flag, running XOR and both
//   valid flags; the next byte starts a new frame.
// Stall on res_o: the waiting result holds. Bytes that close no frame keep
//   flowing; a byte that would make a second result waits in the input
//   register, and in_i.ready drops until the result is taken.
module xor_checked_command_deframer (
  input  logic  clk_i,
  input  logic  rst_ni,
  xcd_in_if.sink    in_i,
  xcd_out_if.source res_o
);
  import xcd_pkg::*;

  rx_item_t      in_item;
  rx_item_t      item;
  logic          item_valid;
  logic          pop;
  logic          push;
  logic          out_free;
  logic          in_ready;
  frame_result_t result_d;
  frame_result_t result_q;

  assign in_item.rx_byte      = in_i.rx_byte;
  assign in_item.end_of_frame = in_i.end_of_frame;
  assign in_i.ready           = in_ready;

  xcd_in_reg u_in_reg (
    .clk_i,
    .rst_ni,
    .valid_i      (in_i.valid),
    .item_i       (in_item),
    .ready_o      (in_ready),
    .item_valid_o (item_valid),
    .item_o       (item),
    .pop_i        (pop)
  );

  xcd_parser u_parser (
    .clk_i,
    .rst_ni,
    .item_valid_i (item_valid),
    .item_i       (item),
    .pop_o        (pop),
    .out_free_i   (out_free),
    .push_o       (push),
    .result_o     (result_d)
  );

  xcd_out_reg u_out_reg (
    .clk_i,
    .rst_ni,
    .push_i   (push),
    .result_i (result_d),
    .free_o   (out_free),
    .valid_o  (res_o.valid),
    .result_o (result_q),
    .ready_i  (res_o.ready)
  );

  assign res_o.frame_status = result_q.frame_status;
  assign res_o.command_code = result_q.command_code;
  assign res_o.length_byte  = result_q.length_byte;
  assign res_o.payload_word = result_q.payload_word;
  assign res_o.check_byte   = result_q.check_byte;

  // A result is never written over one that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (!res_o.valid || res_o.ready))
    else $error("result pushed into a full, stalled result register");

  // Parser consumes only bytes that are really held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> item_valid)
    else $error("parser consumed an empty input register");

  // A held byte the parser cannot take must block the byte channel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_valid && !pop) |-> !in_i.ready)
    else $error("input accepted while the input register is blocked");

  // A pushed result shows up as valid on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> res_o.valid)
    else $error("pushed result did not appear on the result channel");

endmodule
